// ===== rtl/ased_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ased_pkg
// Shared types and constants of the approximate substring edit distance block.
// ----------------------------------------------------------------------------
package ased_pkg;

  localparam int DIST_W    = 6;
  localparam int PAT_WORDS = 4;
  localparam int PAT_BYTES = PAT_WORDS * 8;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  typedef logic [DIST_W-1:0] dist_t;

  localparam dist_t DIST_MAX = dist_t'(63);

  typedef enum logic [2:0] {
    REG_PATTERN_LEN = 3'd0,
    REG_PATTERN_W0  = 3'd1,
    REG_PATTERN_W1  = 3'd2,
    REG_PATTERN_W2  = 3'd3,
    REG_PATTERN_W3  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] text_char;
    logic       last;
    dist_t      above;
    dist_t      diag;
  } link_t;

  typedef struct packed {
    logic advance;
    logic active;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/approx_substring_edit_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// approx_substring_edit_distance
// Streaming approximate substring matcher over a skewed row of pattern cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports         Contents
// in_      in   tdata[7:0]    text_char;  tlast: text_last
// out_     out  tdata[15:0]   end_here_dist, best_dist; tlast: text_done
// cfg_     in   APB, 64 bit   pattern_len @0x00, pattern_word_0..3 @0x08..0x20
//
// One byte enters per cycle while the output is not stalled; a result passes
// through every cell of the row and then the output register.
// The whole row advances together; a stalled output holds every stage.
// Reset loads each cell with its row number plus one and the best with 63.
// ----------------------------------------------------------------------------
module approx_substring_edit_distance #(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_char
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [5:0] end_here_dist, [11:6] best_dist
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [6:0] MAX_LEN = 7'(MAX_PATTERN);

  logic [5:0]                         len_cfg;
  logic [ased_pkg::PAT_BYTES*8-1:0]   pat_bits;
  logic [6:0]                         eff_len;
  logic                               advance;
  ased_pkg::link_t                    links [MAX_PATTERN+1];
  ased_pkg::link_t                    tail;

  logic            out_valid_r;
  ased_pkg::dist_t out_end_r, out_best_r;
  logic            out_last_r;
  ased_pkg::dist_t best_r, best_nxt, best_min;

  assign cfg_pready = 1'b1;

  ased_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pattern_len  (len_cfg),
    .pattern_bits (pat_bits)
  );

  always_comb begin
    priority if (len_cfg == 6'd0) begin
      eff_len = 7'd1;
    end else if ({1'b0, len_cfg} > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = {1'b0, len_cfg};
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  always_comb begin
    links[0].valid     = in_tvalid;
    links[0].text_char = in_tdata;
    links[0].last      = in_tlast;
    links[0].above     = '0;
    links[0].diag      = '0;
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    ased_pkg::cell_ctl_t ctl;
    logic [7:0]          pch;

    assign ctl.advance = advance;
    assign ctl.active  = 7'(g) < eff_len;

    if (g < ased_pkg::PAT_BYTES) begin : g_pat
      assign pch = pat_bits[8*g +: 8];
    end else begin : g_zero
      assign pch = 8'd0;
    end

    ased_cell #(.INDEX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .pat_char (pch),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign tail = links[MAX_PATTERN];

  always_comb begin
    best_min = (tail.above < best_r) ? tail.above : best_r;
    best_nxt = best_r;
    if (tail.valid) begin
      best_nxt = tail.last ? ased_pkg::DIST_MAX : best_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      best_r      <= ased_pkg::DIST_MAX;
    end else if (advance) begin
      out_valid_r <= tail.valid;
      best_r      <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail.valid) begin
      out_end_r  <= tail.above;
      out_best_r <= best_min;
      out_last_r <= tail.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_best_r, out_end_r};
  assign out_tlast  = out_last_r;

  a_best_le_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:6] <= out_tdata[5:0])
    else $error("best distance above distance ending here");

  a_end_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[5:0]} <= eff_len)
    else $error("distance ending here above pattern length");

  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && tail.valid && tail.last) |=> best_r == ased_pkg::DIST_MAX)
    else $error("running best not cleared after last byte");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// ===== rtl/ased_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ased_cfg
// Register file: pattern length and four words of pattern bytes.
// ----------------------------------------------------------------------------
module ased_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ased_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [ased_pkg::DATA_W-1:0]     pwdata,
  output logic      [ased_pkg::DATA_W-1:0]     prdata,
  output logic      [5:0]                      pattern_len,
  output logic      [ased_pkg::PAT_BYTES*8-1:0] pattern_bits
);

  logic [5:0]                    len_r;
  logic [ased_pkg::DATA_W-1:0]   word_r [ased_pkg::PAT_WORDS];
  logic                          wr_en;
  ased_pkg::reg_idx_t            idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = ased_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 6'd1;
      for (int k = 0; k < ased_pkg::PAT_WORDS; k++) begin
        word_r[k] <= '0;
      end
    end else if (wr_en) begin
      unique case (idx)
        ased_pkg::REG_PATTERN_LEN: len_r     <= pwdata[5:0];
        ased_pkg::REG_PATTERN_W0:  word_r[0] <= pwdata;
        ased_pkg::REG_PATTERN_W1:  word_r[1] <= pwdata;
        ased_pkg::REG_PATTERN_W2:  word_r[2] <= pwdata;
        ased_pkg::REG_PATTERN_W3:  word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ased_pkg::REG_PATTERN_LEN: prdata = {58'd0, len_r};
      ased_pkg::REG_PATTERN_W0:  prdata = word_r[0];
      ased_pkg::REG_PATTERN_W1:  prdata = word_r[1];
      ased_pkg::REG_PATTERN_W2:  prdata = word_r[2];
      ased_pkg::REG_PATTERN_W3:  prdata = word_r[3];
      default:                   prdata = '0;
    endcase
  end

  assign pattern_len  = len_r;
  assign pattern_bits = {word_r[3], word_r[2], word_r[1], word_r[0]};

endmodule
`default_nettype wire

// ===== rtl/ased_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ased_cell
// One pattern row: holds its distance entry and passes the text byte on.
// ----------------------------------------------------------------------------
module ased_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ased_pkg::cell_ctl_t ctl,
  input  wire logic [7:0]          pat_char,
  input  wire ased_pkg::link_t     link_in,
  output ased_pkg::link_t          link_out
);

  localparam int          RST_INT = (INDEX + 1 > 63) ? 63 : INDEX + 1;
  localparam ased_pkg::dist_t RST_VAL = ased_pkg::dist_t'(RST_INT);

  ased_pkg::dist_t d_r, d_nxt;
  ased_pkg::link_t link_r, link_nxt;
  logic [6:0]      up_c, above_c, diag_c, min_a, min_b;
  ased_pkg::dist_t best;

  always_comb begin
    up_c    = {1'b0, d_r} + 7'd1;
    above_c = {1'b0, link_in.above} + 7'd1;
    diag_c  = {1'b0, link_in.diag} + 7'((pat_char != link_in.text_char) ? 1 : 0);
    min_a   = (above_c < up_c) ? above_c : up_c;
    min_b   = (diag_c < min_a) ? diag_c : min_a;
    best    = (min_b > {1'b0, ased_pkg::DIST_MAX}) ? ased_pkg::DIST_MAX : min_b[5:0];
  end

  always_comb begin
    d_nxt    = d_r;
    link_nxt = link_in;
    if (ctl.active) begin
      link_nxt.above = best;
      link_nxt.diag  = d_r;
    end
    if (link_in.valid) begin
      priority if (link_in.last) begin
        d_nxt = RST_VAL;
      end else if (ctl.active) begin
        d_nxt = best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r    <= RST_VAL;
      link_r <= '0;
    end else if (ctl.advance) begin
      d_r    <= d_nxt;
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;

endmodule
`default_nettype wire
